[rtl/core/adc_capture_packet_framer_defines.svh]
// assertion macros shared by the framer rtl
// expects clk and rst_n in the scope of each use
`ifndef ADC_CAPTURE_PACKET_FRAMER_DEFINES_SVH
`define ADC_CAPTURE_PACKET_FRAMER_DEFINES_SVH

// same-cycle implication
`define ACPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/acpf_pkg.sv]
// shared types and constants for the adc capture packet framer
// no dependencies
package acpf_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CHAN_MAX     = 8;
  localparam int WORD_W       = 16;
  localparam int TIME_W       = 32;
  localparam int SEQ_W        = 32;
  localparam int OVR_W        = 32;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int HDR_LEN      = 10;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd21;
  localparam logic [CFG_W-1:0] FRAMES_RST       = 16'd128;

  localparam logic [7:0] SYNC0 = 8'hA5;
  localparam logic [7:0] SYNC1 = 8'h5A;
  localparam logic [7:0] SYNC2 = 8'hC3;
  localparam logic [7:0] SYNC3 = 8'h3C;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTERVAL = 1'b0,
    REG_FRAMES       = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             hdr;
    logic [SEQ_W-1:0] seq;
    logic [CFG_W-1:0] fpp;
    logic [OVR_W-1:0] ovr;
  } frame_meta_t;

  localparam int META_W = $bits(frame_meta_t);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/acpf_ifs.sv]
// request channel interfaces of the framer: conversion events in, bytes out
// depends on acpf_pkg
interface acpf_in_if import acpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_us;
  logic              read_busy;
  logic [WORD_W-1:0] chan0;
  logic [WORD_W-1:0] chan1;
  logic [WORD_W-1:0] chan2;
  logic [WORD_W-1:0] chan3;
  logic [WORD_W-1:0] chan4;
  logic [WORD_W-1:0] chan5;
  logic [WORD_W-1:0] chan6;
  logic [WORD_W-1:0] chan7;

  modport source (
    output valid, time_us, read_busy, chan0, chan1, chan2, chan3,
    output chan4, chan5, chan6, chan7,
    input  ready
  );
  modport sink (
    input  valid, time_us, read_busy, chan0, chan1, chan2, chan3,
    input  chan4, chan5, chan6, chan7,
    output ready
  );
endinterface

interface acpf_out_if import acpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             last_of_run;
  logic [OVR_W-1:0] overrun_count;

  modport source (output valid, out_byte, last_of_run, overrun_count, input ready);
  modport sink   (input valid, out_byte, last_of_run, overrun_count, output ready);
endinterface

[rtl/core/adc_capture_packet_framer.sv]
// top level of the adc capture packet framer: front end, queue, serializer
// depends on acpf_pkg, acpf_ifs, acpf_front, acpf_queue, acpf_back
//
// channel   dir  carries
// in_if     in   conversion event: time_us, read_busy, chan0..chan7
// out_if    out  one byte: out_byte, last_of_run, overrun_count
// cfg_*     in   register write: cfg_we, cfg_idx, cfg_wdata
//
// an event is taken every cycle while the two-entry queue has room
// a frame is 2*CHANNELS sample bytes, plus a 10-byte header when it opens a group
// (26 bytes at eight channels); ignored and busy events produce no bytes
// output register holds while out_if.ready is low; queue fills, then in_if.ready drops
// synchronous active-low reset; registers return to 21 us and 128 frames
module adc_capture_packet_framer import acpf_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  acpf_in_if.sink              in_if,
  acpf_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int QW = META_W + CHANNELS * WORD_W;

  q_stat_t       q_stat;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  acpf_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  acpf_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  acpf_back #(.CHANNELS(CHANNELS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

[rtl/core/acpf_front.sv]
// front end: interval filter, overrun count, group tracking, config registers
// depends on acpf_pkg and acpf_in_if; pushes frame requests into the queue
module acpf_front import acpf_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  acpf_in_if.sink                   in_if,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_idx,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  q_stat_t                   q_stat,
  output logic                      q_push,
  output logic [META_W+CHANNELS*WORD_W-1:0] q_wdata
);

  logic [CFG_W-1:0]  min_interval_r;
  logic [CFG_W-1:0]  fpp_r;
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [CFG_W-1:0]  fig_r, fig_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [OVR_W-1:0]  ovr_r, ovr_nxt;

  logic                  accept;
  logic [TIME_W-1:0]     dt;
  logic                  pass;
  logic [CFG_W-1:0]      fig_inc;
  logic [WORD_W-1:0]     chan_all [CHAN_MAX];
  logic [CHANNELS-1:0][WORD_W-1:0] words;
  frame_meta_t           meta;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;
  assign dt          = in_if.time_us - last_time_r;
  assign pass        = dt >= {{(TIME_W-CFG_W){1'b0}}, min_interval_r};
  assign fig_inc     = fig_r + 1'b1;

  assign chan_all[0] = in_if.chan0;
  assign chan_all[1] = in_if.chan1;
  assign chan_all[2] = in_if.chan2;
  assign chan_all[3] = in_if.chan3;
  assign chan_all[4] = in_if.chan4;
  assign chan_all[5] = in_if.chan5;
  assign chan_all[6] = in_if.chan6;
  assign chan_all[7] = in_if.chan7;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      words[c] = chan_all[c];
    end
  end

  always_comb begin
    meta.hdr = (fig_r == '0);
    meta.seq = seq_r;
    meta.fpp = fpp_r;
    meta.ovr = ovr_r;
  end

  assign q_wdata = {meta, words};
  assign q_push  = accept && pass && !in_if.read_busy;

  always_comb begin
    last_time_nxt = last_time_r;
    fig_nxt       = fig_r;
    seq_nxt       = seq_r;
    ovr_nxt       = ovr_r;
    if (accept && pass) begin
      last_time_nxt = in_if.time_us;
      if (in_if.read_busy) begin
        ovr_nxt = ovr_r + 1'b1;
      end else if (fig_inc >= fpp_r || fig_inc == '0) begin
        fig_nxt = '0;
        seq_nxt = seq_r + 1'b1;
      end else begin
        fig_nxt = fig_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= MIN_INTERVAL_RST;
      fpp_r          <= FRAMES_RST;
      last_time_r    <= '0;
      fig_r          <= '0;
      seq_r          <= '0;
      ovr_r          <= '0;
    end else begin
      last_time_r <= last_time_nxt;
      fig_r       <= fig_nxt;
      seq_r       <= seq_nxt;
      ovr_r       <= ovr_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_MIN_INTERVAL: min_interval_r <= cfg_wdata;
          REG_FRAMES:       fpp_r          <= cfg_wdata;
          default:          ;
        endcase
      end
    end
  end

endmodule

[rtl/core/acpf_queue.sv]
// short request queue between front end and serializer
// depends on acpf_pkg and the assertion macro header
`include "adc_capture_packet_framer_defines.svh"
module acpf_queue import acpf_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output q_stat_t      stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  `ACPF_ASSERT_NOW(a_no_push_full, push, !stat.full, "push into full queue")
  `ACPF_ASSERT_NOW(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")
  `ACPF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

[rtl/core/acpf_back.sv]
// serializer: turns one queued frame request into sample bytes, led by header bytes when it opens a group
// depends on acpf_pkg, acpf_out_if and the assertion macro header
`include "adc_capture_packet_framer_defines.svh"
module acpf_back import acpf_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  q_stat_t                           q_stat,
  input  logic [META_W+CHANNELS*WORD_W-1:0] q_rdata,
  output logic                              q_pop,
  acpf_out_if.source                        out_if
);

  localparam int FRAME_BYTES = HDR_LEN + 2 * CHANNELS;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  frame_meta_t                     meta;
  logic [CHANNELS-1:0][WORD_W-1:0] words;

  logic             out_valid_r;
  logic [7:0]       out_byte_r, byte_nxt;
  logic             out_last_r;
  logic [OVR_W-1:0] out_ovr_r;
  logic             mid_r, mid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             load;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] off;
  logic [WORD_W-1:0] word;
  logic             byte_last;

  assign {meta, words} = q_rdata;

  assign load      = !q_stat.empty && (!out_valid_r || out_if.ready);
  assign idx       = mid_r ? idx_r : (meta.hdr ? '0 : IDX_W'(HDR_LEN));
  assign off       = idx - IDX_W'(HDR_LEN);
  assign byte_last = (idx == IDX_W'(FRAME_BYTES - 1));
  assign q_pop     = load && byte_last;
  assign mid_nxt   = !byte_last;
  assign idx_nxt   = idx + 1'b1;

  always_comb begin
    word = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (off[IDX_W-1:1] == (IDX_W-1)'(c)) begin
        word = words[c];
      end
    end
  end

  always_comb begin
    byte_nxt = off[0] ? word[7:0] : word[15:8];
    if (idx < IDX_W'(HDR_LEN)) begin
      unique case (idx)
        IDX_W'(0): byte_nxt = SYNC0;
        IDX_W'(1): byte_nxt = SYNC1;
        IDX_W'(2): byte_nxt = SYNC2;
        IDX_W'(3): byte_nxt = SYNC3;
        IDX_W'(4): byte_nxt = meta.seq[7:0];
        IDX_W'(5): byte_nxt = meta.seq[15:8];
        IDX_W'(6): byte_nxt = meta.seq[23:16];
        IDX_W'(7): byte_nxt = meta.seq[31:24];
        IDX_W'(8): byte_nxt = meta.fpp[7:0];
        IDX_W'(9): byte_nxt = meta.fpp[15:8];
        default:   byte_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_nxt;
      out_last_r <= byte_last;
      out_ovr_r  <= meta.ovr;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mid_r       <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        mid_r       <= mid_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_byte      = out_byte_r;
  assign out_if.last_of_run   = out_last_r;
  assign out_if.overrun_count = out_ovr_r;

  `ACPF_ASSERT_NOW(a_mid_has_head, mid_r, !q_stat.empty, "queue head lost mid frame")
  `ACPF_ASSERT_NEXT(a_last_ends_frame, load && byte_last, !mid_r, "frame did not close")
  `ACPF_ASSERT_NEXT(a_load_valid, load, out_valid_r, "loaded byte not presented")

endmodule
